@@ sv/bcd_clock_with_serial_commands_macros.svh @@
// Assertion macros shared by the clock blocks; they expect clock and reset in scope.
`ifndef BCD_CLOCK_WITH_SERIAL_COMMANDS_MACROS_SVH
`define BCD_CLOCK_WITH_SERIAL_COMMANDS_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define BCDCLK_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define BCDCLK_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BCDCLK_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/bcdclk_pkg.sv @@
// Shared types and constants for the BCD clock with serial commands.
`timescale 1ns / 1ps

package bcdclk_pkg;

   // Beat layout on the request side.
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned SAMPLE_W   = 12;
   localparam int unsigned REQ_DATA_W = 56;
   localparam int unsigned DIGIT_W    = 4;

   // Temperature arithmetic: scaled = avg * 7 stays below 2^15, temp below 2^9.
   localparam int unsigned SCALED_W    = 15;
   localparam int unsigned TEMP_W      = 9;
   localparam int unsigned RECIP100_W  = 18;
   // ceil(2^24 / 100); exact floor division for all scaled values in range.
   localparam logic [RECIP100_W-1:0] RECIP_100 = 18'd167773;
   localparam int unsigned RECIP100_SHIFT = 24;
   // ceil(2^11 / 10); exact for every temperature below 1029.
   localparam logic [7:0] RECIP_10 = 8'd205;
   localparam int unsigned RECIP10_SHIFT = 11;
   localparam int unsigned TENS_W  = 6;

   // Character codes.
   localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] CHAR_HASH   = 8'h23;
   localparam logic [BYTE_W-1:0] CHAR_AMP    = 8'h26;
   localparam logic [BYTE_W-1:0] CHAR_T      = 8'h54;

   // Job queue between the parser and the transmitter.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Byte position inside one job's run.
   localparam int unsigned IDX_W = 3;
   localparam logic [IDX_W-1:0] TEMP_LAST_IDX    = 3'd2;
   localparam logic [IDX_W-1:0] READOUT_LAST_IDX = 3'd6;

   typedef struct packed {
      logic [DIGIT_W-1:0] hour_tens;
      logic [DIGIT_W-1:0] hour_units;
      logic [DIGIT_W-1:0] minute_tens;
      logic [DIGIT_W-1:0] minute_units;
      logic [DIGIT_W-1:0] second_tens;
      logic [DIGIT_W-1:0] second_units;
   } time_type;

   localparam int unsigned PAYLOAD_W = $bits(time_type);

   localparam time_type RESET_TIME = '{
      hour_tens:    4'd1,
      hour_units:   4'd2,
      minute_tens:  4'd4,
      minute_units: 4'd0,
      second_tens:  4'd1,
      second_units: 4'd0
   };

   typedef enum logic {
      JOB_TEMP,
      JOB_READOUT
   } job_kind_type;

   // A temperature job carries avg*7 in the low bits; a readout job a time snapshot.
   typedef struct packed {
      job_kind_type         kind;
      logic [PAYLOAD_W-1:0] payload;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_beat_type;

endpackage

@@ sv/bcdclk_front.sv @@
// Front end: accepts beats, keeps the time and the command parser, queues transmit jobs.
`timescale 1ns / 1ps

module bcdclk_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bcdclk_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                                req_tuser,
   input  logic                                queue_full_i,
   output bcdclk_pkg::job_beat_type            push_o
);

   localparam int unsigned TIME_DIGITS = 8;
   localparam int unsigned SKIP_BYTES  = 6;
   localparam int unsigned COUNT_W     = $clog2(TIME_DIGITS);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_TIME,
      MODE_SKIP
   } mode_type;

   mode_type                            mode_ff, mode_in;
   logic [COUNT_W-1:0]                  count_ff, count_in;
   bcdclk_pkg::time_type                time_ff, time_in, time_tick;
   logic [bcdclk_pkg::DIGIT_W-1:0]      digit_buf_ff [TIME_DIGITS];

   logic                                accept;
   logic                                action;
   logic [bcdclk_pkg::BYTE_W-1:0]       rx_byte;
   logic [bcdclk_pkg::BYTE_W-1:0]       digit_diff;
   logic [bcdclk_pkg::DIGIT_W-1:0]      digit;
   logic                                digit_we;
   logic [bcdclk_pkg::SAMPLE_W+1:0]     sample_sum;
   logic [bcdclk_pkg::SAMPLE_W-1:0]     sample_avg;
   logic [bcdclk_pkg::SCALED_W-1:0]     scaled;

   assign req_tready = !queue_full_i;
   assign accept     = req_tvalid && !queue_full_i;
   assign action     = req_tuser;
   assign rx_byte    = req_tdata[bcdclk_pkg::BYTE_W-1:0];

   // Serial digits are taken as (byte - '0') mod 16.
   assign digit_diff = rx_byte - bcdclk_pkg::CHAR_ZERO;
   assign digit      = digit_diff[bcdclk_pkg::DIGIT_W-1:0];

   // Average of the four samples, then times seven as a shift and subtract.
   assign sample_sum = 14'(req_tdata[19:8]) + 14'(req_tdata[31:20])
                     + 14'(req_tdata[43:32]) + 14'(req_tdata[55:44]);
   assign sample_avg = sample_sum[bcdclk_pkg::SAMPLE_W+1:2];
   assign scaled     = {sample_avg, 3'b000} - 15'(sample_avg);

   // One-second advance with the ripple order of the digit fields.
   always_comb begin
      time_tick = time_ff;
      if (time_ff.second_units < 4'd9) begin
         time_tick.second_units = 4'(time_ff.second_units + 4'd1);
      end else if (time_ff.second_tens < 4'd5) begin
         time_tick.second_tens  = 4'(time_ff.second_tens + 4'd1);
         time_tick.second_units = '0;
      end else if (time_ff.minute_units < 4'd9) begin
         time_tick.minute_units = 4'(time_ff.minute_units + 4'd1);
         time_tick.second_tens  = '0;
         time_tick.second_units = '0;
      end else if (time_ff.minute_tens < 4'd5) begin
         time_tick.minute_tens  = 4'(time_ff.minute_tens + 4'd1);
         time_tick.minute_units = '0;
         time_tick.second_tens  = '0;
         time_tick.second_units = '0;
      end else if (time_ff.hour_units < 4'd9) begin
         time_tick.minute_tens  = '0;
         time_tick.minute_units = '0;
         time_tick.second_tens  = '0;
         time_tick.second_units = '0;
         if (time_ff.hour_tens == 4'd2) begin
            if (time_ff.hour_units < 4'd3) begin
               time_tick.hour_units = 4'(time_ff.hour_units + 4'd1);
            end else begin
               time_tick.hour_tens  = '0;
               time_tick.hour_units = '0;
            end
         end else begin
            time_tick.hour_units = 4'(time_ff.hour_units + 4'd1);
         end
      end else if (time_ff.hour_tens < 4'd2) begin
         time_tick.hour_tens    = 4'(time_ff.hour_tens + 4'd1);
         time_tick.hour_units   = '0;
         time_tick.minute_tens  = '0;
         time_tick.minute_units = '0;
         time_tick.second_tens  = '0;
         time_tick.second_units = '0;
      end
   end

   // Parser and job classification.
   always_comb begin
      mode_in     = mode_ff;
      count_in    = count_ff;
      time_in     = time_ff;
      digit_we    = 1'b0;
      push_o      = '0;
      if (accept) begin
         if (!action) begin
            time_in            = time_tick;
            push_o.valid       = 1'b1;
            push_o.job.kind    = bcdclk_pkg::JOB_TEMP;
            push_o.job.payload = bcdclk_pkg::PAYLOAD_W'(scaled);
         end else begin
            unique case (mode_ff)
               MODE_TIME: begin
                  digit_we = 1'b1;
                  if (count_ff == COUNT_W'(TIME_DIGITS - 1)) begin
                     mode_in  = MODE_IDLE;
                     count_in = '0;
                     // Seconds units come straight from this beat.
                     if (digit_buf_ff[1] != '0) begin
                        time_in.hour_tens    = digit_buf_ff[0];
                        time_in.hour_units   = digit_buf_ff[1];
                        time_in.minute_tens  = digit_buf_ff[3];
                        time_in.minute_units = digit_buf_ff[4];
                        time_in.second_tens  = digit_buf_ff[6];
                        time_in.second_units = digit;
                     end
                  end else begin
                     count_in = COUNT_W'(count_ff + 1'b1);
                  end
               end
               MODE_SKIP: begin
                  if (count_ff == COUNT_W'(SKIP_BYTES - 1)) begin
                     mode_in  = MODE_IDLE;
                     count_in = '0;
                  end else begin
                     count_in = COUNT_W'(count_ff + 1'b1);
                  end
               end
               default: begin
                  mode_in = MODE_IDLE;
                  unique case (rx_byte)
                     bcdclk_pkg::CHAR_DOLLAR: begin
                        mode_in  = MODE_TIME;
                        count_in = '0;
                     end
                     bcdclk_pkg::CHAR_HASH: begin
                        mode_in  = MODE_SKIP;
                        count_in = '0;
                     end
                     bcdclk_pkg::CHAR_AMP: begin
                        push_o.valid       = 1'b1;
                        push_o.job.kind    = bcdclk_pkg::JOB_READOUT;
                        push_o.job.payload = time_ff;
                     end
                     default: begin
                        mode_in = MODE_IDLE;
                     end
                  endcase
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         count_ff <= '0;
         time_ff  <= bcdclk_pkg::RESET_TIME;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         time_ff  <= time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (digit_we) begin
         digit_buf_ff[count_ff] <= digit;
      end
   end

endmodule

@@ sv/bcdclk_queue.sv @@
// Short job queue between the parser front end and the transmitter.
`timescale 1ns / 1ps
`include "bcd_clock_with_serial_commands_macros.svh"

module bcdclk_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  bcdclk_pkg::job_beat_type push_i,
   input  logic                     pop_i,
   output bcdclk_pkg::job_beat_type head_o,
   output logic                     full_o
);

   localparam int unsigned DEPTH = bcdclk_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = bcdclk_pkg::QUEUE_PTR_W;
   localparam int unsigned CNT_W = bcdclk_pkg::QUEUE_CNT_W;

   bcdclk_pkg::job_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff;

   assign full_o       = (count_ff == CNT_W'(DEPTH));
   assign head_o.valid = (count_ff != '0);
   assign head_o.job   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_i.valid) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
         end
         if (pop_i) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
         end
         case ({push_i.valid, pop_i})
            2'b10:   count_ff <= CNT_W'(count_ff + 1'b1);
            2'b01:   count_ff <= CNT_W'(count_ff - 1'b1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push_i.valid) begin
         entry_ff[wr_ptr_ff] <= push_i.job;
      end
   end

   `BCDCLK_ASSERT_IMPLY(a_push_not_full, push_i.valid, !full_o, "job pushed into a full queue")
   `BCDCLK_ASSERT_IMPLY(a_pop_not_empty, pop_i, count_ff != '0, "job popped from an empty queue")
   `BCDCLK_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

@@ sv/bcdclk_back.sv @@
// Back end: turns queued jobs into the transmitted byte runs behind an output register.
`timescale 1ns / 1ps
`include "bcd_clock_with_serial_commands_macros.svh"

module bcdclk_back (
   input  logic                              clock,
   input  logic                              reset,
   input  bcdclk_pkg::job_beat_type          head_i,
   output logic                              pop_o,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bcdclk_pkg::BYTE_W-1:0]     rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int unsigned IDX_W     = bcdclk_pkg::IDX_W;
   localparam int unsigned TEMP_W    = bcdclk_pkg::TEMP_W;
   localparam int unsigned TENS_W    = bcdclk_pkg::TENS_W;
   localparam int unsigned TPROD_W   = bcdclk_pkg::SCALED_W + bcdclk_pkg::RECIP100_W;
   localparam int unsigned DPROD_W   = TEMP_W + 8;

   logic                               active_ff;
   logic [IDX_W-1:0]                   idx_ff;
   bcdclk_pkg::job_kind_type           kind_ff;
   logic [bcdclk_pkg::PAYLOAD_W-1:0]   payload_ff;
   logic [TEMP_W-1:0]                  temp_ff;
   logic                               out_valid_ff;
   logic [bcdclk_pkg::BYTE_W-1:0]      out_data_ff;
   logic                               out_last_ff;

   logic                               slot_free;
   logic                               emit;
   logic                               emit_last;
   logic                               load;
   logic [IDX_W-1:0]                   last_idx;
   logic [TPROD_W-1:0]                 temp_prod;
   logic [TEMP_W-1:0]                  temp_in;
   logic [DPROD_W-1:0]                 tens_prod;
   logic [TENS_W-1:0]                  tens;
   logic [TEMP_W-1:0]                  units_diff;
   bcdclk_pkg::time_type               snap;
   logic [bcdclk_pkg::BYTE_W-1:0]      byte_out;

   assign slot_free = !out_valid_ff || rsp_tready;
   assign last_idx  = (kind_ff == bcdclk_pkg::JOB_TEMP) ? bcdclk_pkg::TEMP_LAST_IDX
                                                        : bcdclk_pkg::READOUT_LAST_IDX;
   assign emit      = active_ff && slot_free;
   assign emit_last = emit && (idx_ff == last_idx);
   // The next job is taken in the cycle that sends the last byte of the current one.
   assign load      = head_i.valid && (!active_ff || emit_last);
   assign pop_o     = load;

   // temp = floor(scaled / 100) by reciprocal multiply, registered at load.
   assign temp_prod = TPROD_W'(head_i.job.payload[bcdclk_pkg::SCALED_W-1:0])
                    * TPROD_W'(bcdclk_pkg::RECIP_100);
   assign temp_in   = TEMP_W'(temp_prod >> bcdclk_pkg::RECIP100_SHIFT);

   // Tens and units of the registered temperature.
   assign tens_prod  = DPROD_W'(temp_ff) * DPROD_W'(bcdclk_pkg::RECIP_10);
   assign tens       = TENS_W'(tens_prod >> bcdclk_pkg::RECIP10_SHIFT);
   assign units_diff = temp_ff - TEMP_W'(TEMP_W'(tens) * TEMP_W'(10));

   assign snap = bcdclk_pkg::time_type'(payload_ff);

   always_comb begin
      byte_out = '0;
      case (kind_ff)
         bcdclk_pkg::JOB_TEMP: begin
            case (idx_ff)
               3'd0:    byte_out = bcdclk_pkg::CHAR_T;
               3'd1:    byte_out = bcdclk_pkg::CHAR_ZERO + 8'(tens);
               default: byte_out = bcdclk_pkg::CHAR_ZERO + 8'(units_diff[3:0]);
            endcase
         end
         default: begin
            case (idx_ff)
               3'd0:    byte_out = bcdclk_pkg::CHAR_AMP;
               3'd1:    byte_out = 8'(snap.second_units);
               3'd2:    byte_out = 8'(snap.second_tens);
               3'd3:    byte_out = 8'(snap.minute_units);
               3'd4:    byte_out = 8'(snap.minute_tens);
               3'd5:    byte_out = 8'(snap.hour_units);
               default: byte_out = 8'(snap.hour_tens);
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            active_ff <= 1'b1;
            idx_ff    <= '0;
         end else if (emit_last) begin
            active_ff <= 1'b0;
         end else if (emit) begin
            idx_ff <= IDX_W'(idx_ff + 1'b1);
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= head_i.job.kind;
         payload_ff <= head_i.job.payload;
         temp_ff    <= temp_in;
      end
      if (emit) begin
         out_data_ff <= byte_out;
         out_last_ff <= (idx_ff == last_idx);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   `BCDCLK_ASSERT_IMPLY(a_idx_in_run, active_ff, idx_ff <= last_idx, "byte index past end of run")
   `BCDCLK_ASSERT_IMPLY(a_mid_run_active, rsp_tvalid && rsp_tready && !rsp_tlast, active_ff,
      "non-final beat taken with no job in progress")
   `BCDCLK_ASSERT_NEXT(a_load_starts_run, load, active_ff && (idx_ff == '0),
      "loaded job did not start at its first byte")

endmodule

@@ sv/bcd_clock_with_serial_commands.sv @@
// Top level of the 24-hour BCD clock with serial command parser and temperature report.
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// req_*     in         tuser: action (0 tick, 1 serial byte); tdata: rx_byte, sample_a..d
// rsp_*     out        tdata: tx_byte; tlast: final byte of the item's run
//
// A tick beat yields three bytes ('T' and two temperature digits), an '&' beat with the
// parser idle seven bytes (the time as raw digits), every other beat none. From an idle
// block the first byte passes the job queue, the job registers and the output register.
// Bytes go out one a cycle while rsp_tready holds; the next job loads with the last byte.
// A stalled result side fills the four-entry job queue, and only then req_tready drops.
// Reset is synchronous and active high; it sets the time to 12:40:10 with the parser idle.
module bcd_clock_with_serial_commands (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Bits from low: rx_byte[7:0], sample_a[19:8], sample_b[31:20], sample_c[43:32],
   // sample_d[55:44].
   input  logic [bcdclk_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Bits from low: action[0].
   input  logic                                req_tuser,
   // Result channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Bits from low: tx_byte[7:0].
   output logic [bcdclk_pkg::BYTE_W-1:0]       rsp_tdata,
   output logic                                rsp_tlast
);

   bcdclk_pkg::job_beat_type push;
   bcdclk_pkg::job_beat_type head;
   logic                     queue_full;
   logic                     pop;

   // The front end owns the time and the parser; it queues one job per reporting beat.
   bcdclk_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .queue_full_i (queue_full),
      .push_o       (push)
   );

   // Jobs wait here so the parser keeps running while the transmitter is stalled.
   bcdclk_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push_i (push),
      .pop_i  (pop),
      .head_o (head),
      .full_o (queue_full)
   );

   // The back end expands each job into its byte run behind an output register.
   bcdclk_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_i     (head),
      .pop_o      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ tb/tb_bcd_clock_with_serial_commands.sv @@
// Self-checking testbench for the BCD clock with serial commands, using a cycle-free predictor.
`timescale 1ns / 1ps

// The testbench feeds tick beats and serial-byte beats into the request channel and checks
// every byte on the result channel against its own model of the clock.
//
// How it works:
// - An initial block fills a queue of pending beats. A short directed part comes first.
//   The random part follows. It is mostly well-formed time loads ('$' and eight bytes) and
//   skip commands ('#' and six bytes) with random content and ticks mixed in. It also
//   holds readouts ('&'), plain ticks, broken commands and noise bytes.
// - The driver is a clocked always block. It sends beats in bursts of random length with
//   random gaps between them. A beat flagged for it waits until every expected byte has
//   arrived.
// - The monitor is a clocked always block. On each accepted request beat it updates the
//   predicted clock and parser state and queues the bytes that beat should produce. On
//   each accepted result beat it compares the byte and its last flag with the oldest
//   expectation.
// - The result side stalls on a pattern of its own. The pattern switches between always
//   ready, coin-flip ready and mostly stalled.
module tb_bcd_clock_with_serial_commands;

   // Widths and character codes from the shared package.
   localparam int unsigned BYTE_W     = bcdclk_pkg::BYTE_W;
   localparam int unsigned SAMPLE_W   = bcdclk_pkg::SAMPLE_W;
   localparam int unsigned REQ_DATA_W = bcdclk_pkg::REQ_DATA_W;
   localparam int unsigned DIGIT_W    = bcdclk_pkg::DIGIT_W;

   localparam logic [BYTE_W-1:0] CHAR_ZERO   = bcdclk_pkg::CHAR_ZERO;
   localparam logic [BYTE_W-1:0] CHAR_DOLLAR = bcdclk_pkg::CHAR_DOLLAR;
   localparam logic [BYTE_W-1:0] CHAR_HASH   = bcdclk_pkg::CHAR_HASH;
   localparam logic [BYTE_W-1:0] CHAR_AMP    = bcdclk_pkg::CHAR_AMP;
   localparam logic [BYTE_W-1:0] CHAR_T      = bcdclk_pkg::CHAR_T;

   localparam logic ACTION_TICK = 1'b0;
   localparam logic ACTION_BYTE = 1'b1;

   // The temperature is the sample average scaled by 7/100, truncated.
   localparam int unsigned TEMP_MUL = 7;
   localparam int unsigned TEMP_DIV = 100;

   localparam int unsigned TIME_BYTES   = 8;
   localparam int unsigned SKIP_BYTES   = 6;
   localparam int unsigned RANDOM_BEATS = 500;
   localparam int unsigned END_DRAIN    = 30;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

   typedef enum logic [1:0] {
      PARSE_IDLE,
      PARSE_TIME,
      PARSE_SKIP
   } parse_mode_type;

   // One pending request beat, plus a flag that holds it back until all results are in.
   typedef struct packed {
      logic                action;
      logic [BYTE_W-1:0]   rx_byte;
      logic [SAMPLE_W-1:0] sample_a;
      logic [SAMPLE_W-1:0] sample_b;
      logic [SAMPLE_W-1:0] sample_c;
      logic [SAMPLE_W-1:0] sample_d;
      logic                wait_for_drain;
   } clock_beat_type;

   // One expected result beat.
   typedef struct packed {
      logic [BYTE_W-1:0] tx_byte;
      logic              last_byte;
   } tx_beat_type;

   // Every input of the block starts from a known value.
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [BYTE_W-1:0]     rsp_tdata;
   logic                  rsp_tlast;

   clock_beat_type beat_queue[$];
   tx_beat_type    tx_expect[$];
   int unsigned    mismatch_count = 0;
   int unsigned    beats_accepted = 0;
   int unsigned    beats_total    = 0;

   // Predicted state of the block.
   bcdclk_pkg::time_type clk_time;
   parse_mode_type       parse_mode;
   logic [3:0]           digit_count;
   logic [DIGIT_W-1:0]   digit_buf[TIME_BYTES];

   // Driver pacing.
   int burst_left = 0;
   int gap_left   = 0;

   // Receiver stall pattern.
   int stall_mode = 0;
   int mode_left  = 0;

   bcd_clock_with_serial_commands dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Each mismatch is one printed line and one count.
   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t: mismatch: %s", $realtime, what);
   endtask

   function automatic void push_tx(input logic [BYTE_W-1:0] value);
      tx_expect.push_back('{tx_byte: value, last_byte: 1'b0});
   endfunction

   // Ripple order: seconds units, seconds tens, minute units, minute tens, then hours.
   // Hour units of 9 or more under hour tens of 2 or more leave the time frozen at rollover.
   function automatic void advance_clock_time();
      if (clk_time.second_units < 4'd9) begin
         clk_time.second_units = clk_time.second_units + 4'd1;
      end else if (clk_time.second_tens < 4'd5) begin
         clk_time.second_tens  = clk_time.second_tens + 4'd1;
         clk_time.second_units = 4'd0;
      end else if (clk_time.minute_units < 4'd9) begin
         clk_time.minute_units = clk_time.minute_units + 4'd1;
         clk_time.second_tens  = 4'd0;
         clk_time.second_units = 4'd0;
      end else if (clk_time.minute_tens < 4'd5) begin
         clk_time.minute_tens  = clk_time.minute_tens + 4'd1;
         clk_time.minute_units = 4'd0;
         clk_time.second_tens  = 4'd0;
         clk_time.second_units = 4'd0;
      end else if (clk_time.hour_units < 4'd9) begin
         clk_time.minute_tens  = 4'd0;
         clk_time.minute_units = 4'd0;
         clk_time.second_tens  = 4'd0;
         clk_time.second_units = 4'd0;
         // At 23:59:59, and with any hour units of 3 or more under a tens digit of 2,
         // the whole time wraps to midnight.
         if (clk_time.hour_tens == 4'd2 && clk_time.hour_units >= 4'd3) begin
            clk_time.hour_tens  = 4'd0;
            clk_time.hour_units = 4'd0;
         end else begin
            clk_time.hour_units = clk_time.hour_units + 4'd1;
         end
      end else if (clk_time.hour_tens < 4'd2) begin
         clk_time.hour_tens    = clk_time.hour_tens + 4'd1;
         clk_time.hour_units   = 4'd0;
         clk_time.minute_tens  = 4'd0;
         clk_time.minute_units = 4'd0;
         clk_time.second_tens  = 4'd0;
         clk_time.second_units = 4'd0;
      end
   endfunction

   // Loads the collected time only when the hour units digit is nonzero.
   // The six used buffer entries clear after a load.
   function automatic void finish_time_load();
      if (digit_buf[1] != '0) begin
         clk_time.hour_tens    = digit_buf[0];
         clk_time.hour_units   = digit_buf[1];
         clk_time.minute_tens  = digit_buf[3];
         clk_time.minute_units = digit_buf[4];
         clk_time.second_tens  = digit_buf[6];
         clk_time.second_units = digit_buf[7];
         digit_buf[0] = '0;
         digit_buf[1] = '0;
         digit_buf[3] = '0;
         digit_buf[4] = '0;
         digit_buf[6] = '0;
         digit_buf[7] = '0;
      end
      parse_mode  = PARSE_IDLE;
      digit_count = '0;
   endfunction

   // Updates the predicted state for one accepted request beat and queues its bytes.
   function automatic void predict_clock_beat(input logic action,
                                              input logic [REQ_DATA_W-1:0] data);
      logic [BYTE_W-1:0] rx_byte;
      logic [BYTE_W-1:0] offset_byte;
      int unsigned       sample_sum;
      int unsigned       temp;
      int unsigned       queued_before;
      rx_byte       = data[7:0];
      queued_before = tx_expect.size();
      if (action == ACTION_TICK) begin
         sample_sum = int'(data[19:8]) + int'(data[31:20]) + int'(data[43:32])
                    + int'(data[55:44]);
         temp = ((sample_sum / 4) * TEMP_MUL) / TEMP_DIV;
         advance_clock_time();
         // Above 99 degrees the tens byte runs past '9' unclamped.
         push_tx(CHAR_T);
         push_tx(8'(CHAR_ZERO + temp / 10));
         push_tx(8'(CHAR_ZERO + temp % 10));
      end else begin
         case (parse_mode)
            PARSE_TIME: begin
               // Every byte is data here, command characters included.
               if (digit_count < TIME_BYTES) begin
                  offset_byte = rx_byte - CHAR_ZERO;
                  digit_buf[digit_count[2:0]] = offset_byte[DIGIT_W-1:0];
                  digit_count = digit_count + 4'd1;
               end
               if (digit_count >= TIME_BYTES) begin
                  finish_time_load();
               end
            end
            PARSE_SKIP: begin
               digit_count = digit_count + 4'd1;
               if (digit_count >= SKIP_BYTES) begin
                  parse_mode  = PARSE_IDLE;
                  digit_count = '0;
               end
            end
            default: begin
               parse_mode = PARSE_IDLE;
               if (rx_byte == CHAR_DOLLAR) begin
                  parse_mode  = PARSE_TIME;
                  digit_count = '0;
               end else if (rx_byte == CHAR_HASH) begin
                  parse_mode  = PARSE_SKIP;
                  digit_count = '0;
               end else if (rx_byte == CHAR_AMP) begin
                  // The readout sends the raw digit values, seconds first.
                  push_tx(CHAR_AMP);
                  push_tx({4'd0, clk_time.second_units});
                  push_tx({4'd0, clk_time.second_tens});
                  push_tx({4'd0, clk_time.minute_units});
                  push_tx({4'd0, clk_time.minute_tens});
                  push_tx({4'd0, clk_time.hour_units});
                  push_tx({4'd0, clk_time.hour_tens});
               end
            end
         endcase
      end
      if (tx_expect.size() > queued_before) begin
         tx_expect[tx_expect.size() - 1].last_byte = 1'b1;
      end
   endfunction

   // Samples favor the two ends of the range.
   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return SAMPLE_MAX;
         default: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
      endcase
   endfunction

   // A tick carries a random, unused byte field.
   task automatic queue_tick(input logic [SAMPLE_W-1:0] sa, input logic [SAMPLE_W-1:0] sb,
                             input logic [SAMPLE_W-1:0] sc, input logic [SAMPLE_W-1:0] sd);
      beat_queue.push_back('{action: ACTION_TICK, rx_byte: BYTE_W'($urandom),
                             sample_a: sa, sample_b: sb, sample_c: sc, sample_d: sd,
                             wait_for_drain: 1'b0});
   endtask

   task automatic queue_random_tick();
      if ($urandom_range(0, 19) == 0) begin
         queue_tick(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
      end else begin
         queue_tick(random_sample(), random_sample(), random_sample(), random_sample());
      end
   endtask

   // A serial byte carries random, unused sample fields.
   task automatic queue_byte(input logic [BYTE_W-1:0] value, input logic hold = 1'b0);
      beat_queue.push_back('{action: ACTION_BYTE, rx_byte: value,
                             sample_a: SAMPLE_W'($urandom), sample_b: SAMPLE_W'($urandom),
                             sample_c: SAMPLE_W'($urandom), sample_d: SAMPLE_W'($urandom),
                             wait_for_drain: hold});
   endtask

   // Only the low nibble matters for a digit, so the high nibble is sometimes scrambled.
   function automatic logic [BYTE_W-1:0] digit_byte(input logic [DIGIT_W-1:0] digit);
      if ($urandom_range(0, 3) == 0) begin
         return {4'($urandom), digit};
      end
      return {CHAR_ZERO[7:4], digit};
   endfunction

   // A '$' command with ticks mixed in at the given percentage.
   task automatic queue_time_load(input logic [3:0] ht, input logic [3:0] hu,
                                  input logic [3:0] mt, input logic [3:0] mu,
                                  input logic [3:0] st, input logic [3:0] su,
                                  input int unsigned tick_pct);
      logic [DIGIT_W-1:0] load_digits[TIME_BYTES];
      load_digits = '{ht, hu, 4'd0, mt, mu, 4'd0, st, su};
      queue_byte(CHAR_DOLLAR);
      for (int i = 0; i < TIME_BYTES; i++) begin
         if ($urandom_range(0, 99) < tick_pct) begin
            queue_random_tick();
         end
         // Entries two and five are separators that the block never reads.
         if (i == 2 || i == 5) begin
            queue_byte(BYTE_W'($urandom));
         end else begin
            queue_byte(digit_byte(load_digits[i]));
         end
      end
   endtask

   // A random time load, often close to a rollover, sometimes with non-decimal digits
   // or a zero hour units digit that rejects the load. Up to three ticks and at times a readout follow.
   task automatic queue_random_load();
      logic [3:0]  ht, hu, mt, mu, st, su;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
         {ht, hu, mt, mu, st, su} = 24'($urandom);
      end else begin
         ht = 4'($urandom_range(0, 2));
         hu = (ht == 4'd2) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 9));
         if (pick < 6) begin
            if (ht != 4'd2 && $urandom_range(0, 1) == 1) begin
               hu = 4'd9;
            end
            mt = 4'd5;
            mu = 4'd9;
            st = 4'd5;
            su = 4'(9 - $urandom_range(0, 2));
         end else begin
            mt = 4'($urandom_range(0, 5));
            mu = 4'($urandom_range(0, 9));
            st = 4'($urandom_range(0, 5));
            su = 4'($urandom_range(0, 9));
         end
      end
      if ($urandom_range(0, 7) == 0) begin
         hu = 4'd0;
      end
      queue_time_load(ht, hu, mt, mu, st, su, $urandom_range(0, 15));
      repeat ($urandom_range(0, 3)) queue_random_tick();
      if ($urandom_range(0, 1) == 1) begin
         queue_byte(CHAR_AMP);
      end
   endtask

   // A '#' command whose six swallowed bytes lean toward command characters.
   task automatic queue_skip(input int unsigned tick_pct);
      queue_byte(CHAR_HASH);
      for (int i = 0; i < SKIP_BYTES; i++) begin
         if ($urandom_range(0, 99) < tick_pct) begin
            queue_random_tick();
         end
         case ($urandom_range(0, 4))
            0:       queue_byte(CHAR_AMP);
            1:       queue_byte(CHAR_DOLLAR);
            2:       queue_byte(CHAR_HASH);
            default: queue_byte(BYTE_W'($urandom));
         endcase
      end
   endtask

   // Sends beats in bursts with random gaps. A beat flagged to wait for the drain goes out
   // only when no beat is in flight and nothing is expected any more.
   always @(posedge clock) begin : driver
      clock_beat_type beat;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left != 0) begin
            req_tvalid <= 1'b0;
            gap_left   <= gap_left - 1;
         end else if (beat_queue.size() != 0 &&
                      (!beat_queue[0].wait_for_drain ||
                       (!req_tvalid && tx_expect.size() == 0))) begin
            beat = beat_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= beat.action;
            req_tdata  <= {beat.sample_d, beat.sample_c, beat.sample_b, beat.sample_a,
                           beat.rx_byte};
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               // A third of the bursts run straight into the next one.
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // The result side switches between always ready, coin-flip ready and mostly stalled.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         mode_left  <= $urandom_range(20, 300);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   // Predicts on accepted request beats and checks accepted result beats. Prediction comes
   // first, so a result that came in the same cycle as its request would still find its
   // expectation.
   always @(posedge clock) begin : monitor
      tx_beat_type want;
      if (reset) begin
         clk_time    = bcdclk_pkg::RESET_TIME;
         parse_mode  = PARSE_IDLE;
         digit_count = '0;
         foreach (digit_buf[i]) digit_buf[i] = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_clock_beat(req_tuser, req_tdata);
            beats_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (tx_expect.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h last %0b", rsp_tdata,
                                         rsp_tlast));
            end else begin
               want = tx_expect.pop_front();
               if (rsp_tdata !== want.tx_byte) begin
                  report_mismatch($sformatf("tx_byte %02h, expected %02h", rsp_tdata,
                                            want.tx_byte));
               end
               if (rsp_tlast !== want.last_byte) begin
                  report_mismatch($sformatf("last flag %0b, expected %0b on byte %02h",
                                            rsp_tlast, want.last_byte, want.tx_byte));
               end
            end
         end
      end
   end

   initial begin
      int unsigned pick;

      // Directed part. Read out the reset time first, then take the coolest and the
      // hottest temperature readings. A stray byte is ignored.
      queue_byte(CHAR_AMP);
      queue_tick('0, '0, '0, '0);
      queue_tick(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
      queue_byte(8'h78);
      // Load 23:59:59 and tick past midnight.
      queue_time_load(4'd2, 4'd3, 4'd5, 4'd9, 4'd5, 4'd9, 0);
      queue_tick(SAMPLE_MAX, '0, SAMPLE_MAX, '0);
      queue_byte(CHAR_AMP);
      // A skip command swallows command characters, and a tick in the middle of it is
      // still handled in full.
      queue_byte(CHAR_HASH);
      queue_byte(CHAR_AMP);
      queue_byte(CHAR_DOLLAR);
      queue_byte(CHAR_HASH);
      queue_random_tick();
      queue_byte(8'h41);
      queue_byte(8'hFF);
      queue_byte(8'h00);
      // The parser is idle again. This readout waits until the block has drained.
      queue_byte(CHAR_AMP, 1'b1);

      // Random part, mostly well-formed commands.
      while (beat_queue.size() < RANDOM_BEATS + 25) begin
         pick = $urandom_range(0, 99);
         if (pick < 32) begin
            queue_random_tick();
         end else if (pick < 46) begin
            queue_byte(CHAR_AMP, $urandom_range(0, 49) == 0);
         end else if (pick < 72) begin
            queue_random_load();
         end else if (pick < 80) begin
            queue_skip($urandom_range(0, 20));
         end else if (pick < 87) begin
            // A broken time load. The bytes that follow complete it as data.
            queue_byte(CHAR_DOLLAR);
            repeat ($urandom_range(0, 7)) queue_byte(digit_byte(4'($urandom)));
         end else begin
            queue_byte(BYTE_W'($urandom));
         end
      end
      beats_total = beat_queue.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait for every beat to be taken and every expected byte to come back.
      while (beats_accepted < beats_total) @(posedge clock);
      while (tx_expect.size() != 0) @(posedge clock);
      repeat (END_DRAIN) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // A run that hangs ends here as a failure.
   initial begin
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
